>>> design/mpse_pkg.sv
// Package for the MessagePack scalar encoder.
// Holds request codes, format prefix bytes and the command word type.
// No dependencies.
package mpse_pkg;

  typedef enum logic [1:0] {
    REQ_INT   = 2'd0,
    REQ_F32   = 2'd1,
    REQ_F64   = 2'd2,
    REQ_ARRAY = 2'd3
  } req_e;

  localparam logic [7:0] PfxFixArray = 8'h90;
  localparam logic [7:0] PfxArray16  = 8'hdc;
  localparam logic [7:0] PfxArray32  = 8'hdd;
  localparam logic [7:0] PfxFloat32  = 8'hca;
  localparam logic [7:0] PfxFloat64  = 8'hcb;
  localparam logic [7:0] PfxUint8    = 8'hcc;
  localparam logic [7:0] PfxUint16   = 8'hcd;
  localparam logic [7:0] PfxUint32   = 8'hce;
  localparam logic [7:0] PfxUint64   = 8'hcf;
  localparam logic [7:0] PfxInt8     = 8'hd0;
  localparam logic [7:0] PfxInt16    = 8'hd1;
  localparam logic [7:0] PfxInt32    = 8'hd2;
  localparam logic [7:0] PfxInt64    = 8'hd3;

  localparam int unsigned QueueDepthDefault = 2;

  // one classified item: header byte, then nbytes of data taken from data[63:56] on
  typedef struct packed {
    logic [7:0]  hdr;
    logic [3:0]  nbytes;
    logic        err;
    logic [63:0] data;
  } cmd_t;

endpackage

>>> design/mpse_front.sv
// Front end: accepts an item and classifies it into a command word.
// Depends on mpse_pkg.
module mpse_front import mpse_pkg::*; (
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  req_type_i,
  input  logic [63:0] value_i,
  input  logic        q_full_i,
  output logic        push_o,
  output cmd_t        cmd_o
);

  logic [63:0] u;
  logic [7:0]  hdr;
  logic [3:0]  nb;
  logic        err;

  assign u          = value_i;
  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  always_comb begin
    hdr = u[7:0];
    nb  = 4'd0;
    err = 1'b0;
    case (req_e'(req_type_i))
      REQ_INT: begin
        if (!u[63]) begin
          if (u[63:7] == '0) begin
            hdr = u[7:0];     nb = 4'd0;
          end else if (u[63:8] == '0) begin
            hdr = PfxUint8;   nb = 4'd1;
          end else if (u[63:16] == '0) begin
            hdr = PfxUint16;  nb = 4'd2;
          end else if (u[63:32] == '0) begin
            hdr = PfxUint32;  nb = 4'd4;
          end else begin
            hdr = PfxUint64;  nb = 4'd8;
          end
        end else begin
          if (&u[63:5]) begin
            hdr = u[7:0];     nb = 4'd0;
          end else if (&u[63:7]) begin
            hdr = PfxInt8;    nb = 4'd1;
          end else if (&u[63:15]) begin
            hdr = PfxInt16;   nb = 4'd2;
          end else if (&u[63:31]) begin
            hdr = PfxInt32;   nb = 4'd4;
          end else begin
            hdr = PfxInt64;   nb = 4'd8;
          end
        end
      end
      REQ_F32: begin
        hdr = PfxFloat32; nb = 4'd4;
      end
      REQ_F64: begin
        hdr = PfxFloat64; nb = 4'd8;
      end
      REQ_ARRAY: begin
        if (u[63:4] == '0) begin
          hdr = PfxFixArray | {4'd0, u[3:0]}; nb = 4'd0;
        end else if (u[63:16] == '0) begin
          hdr = PfxArray16; nb = 4'd2;
        end else if (u[63:32] == '0) begin
          hdr = PfxArray32; nb = 4'd4;
        end else begin
          hdr = 8'd0; nb = 4'd0; err = 1'b1;
        end
      end
      default: begin
        hdr = 8'd0; nb = 4'd0;
      end
    endcase
  end

  // left-align the data bytes so the back end always sends the top byte
  always_comb begin
    cmd_o.hdr    = hdr;
    cmd_o.nbytes = nb;
    cmd_o.err    = err;
    case (nb)
      4'd1:    cmd_o.data = {u[7:0], 56'd0};
      4'd2:    cmd_o.data = {u[15:0], 48'd0};
      4'd4:    cmd_o.data = {u[31:0], 32'd0};
      default: cmd_o.data = u;
    endcase
  end

endmodule

>>> design/mpse_queue.sv
// Command queue between front and back ends (power-of-two depth, >= 2).
// Depends on mpse_pkg.
module mpse_queue import mpse_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output cmd_t cmd_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign cmd_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

>>> design/mpse_back.sv
// Back end: pops command words and sends them a byte at a time.
// Depends on mpse_pkg.
module mpse_back import mpse_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_empty_i,
  input  cmd_t       cmd_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       last_o,
  output logic       error_o
);

  logic        ov_q, ov_d;
  logic [7:0]  byte_q, byte_d;
  logic        last_q, last_d;
  logic        err_q, err_d;
  logic [63:0] data_q, data_d;
  logic [3:0]  rem_q, rem_d;
  logic        out_free;

  assign out_free = !ov_q || !out_stall_i;
  assign pop_o    = out_free && (rem_q == '0) && !q_empty_i;

  always_comb begin
    ov_d   = ov_q;
    byte_d = byte_q;
    last_d = last_q;
    err_d  = err_q;
    data_d = data_q;
    rem_d  = rem_q;
    if (out_free) begin
      ov_d = 1'b0;
      if (rem_q != '0) begin
        ov_d   = 1'b1;
        byte_d = data_q[63:56];
        last_d = (rem_q == 4'd1);
        err_d  = 1'b0;
        data_d = {data_q[55:0], 8'd0};
        rem_d  = rem_q - 4'd1;
      end else if (!q_empty_i) begin
        ov_d   = 1'b1;
        byte_d = cmd_i.hdr;
        last_d = (cmd_i.nbytes == '0);
        err_d  = cmd_i.err;
        data_d = cmd_i.data;
        rem_d  = cmd_i.nbytes;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q  <= 1'b0;
      rem_q <= '0;
    end else begin
      ov_q  <= ov_d;
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    last_q <= last_d;
    err_q  <= err_d;
    data_q <= data_d;
  end

  assign out_valid_o = ov_q;
  assign out_byte_o  = byte_q;
  assign last_o      = last_q;
  assign error_o     = err_q;

endmodule

>>> design/msgpack_scalar_encoder_top.sv
// MessagePack scalar encoder, top level: front end, command queue, back end.
// Depends on mpse_pkg, mpse_front, mpse_queue, mpse_back.
// The first byte of an item passes through the command queue, then the back end's
// output register. Each item leaves as a header byte and n data bytes (n = 0 to 8,
//   by its form), in turn; the next item is popped once its last byte is taken.
// Reset (async, active low) empties the queue and drops any output in flight.
module msgpack_scalar_encoder_top import mpse_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  req_type_i,
  input  logic signed [63:0] value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        last_o,
  output logic        error_o
);

  logic push, full, pop, empty;
  cmd_t cmd_in, cmd_out;

  mpse_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .req_type_i (req_type_i),
    .value_i    (value_i),
    .q_full_i   (full),
    .push_o     (push),
    .cmd_o      (cmd_in)
  );

  mpse_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd_in),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .cmd_o   (cmd_out)
  );

  mpse_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (empty),
    .cmd_i       (cmd_out),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .last_o      (last_o),
    .error_o     (error_o)
  );

endmodule

>>> design/mpse_checker.sv
// Port-level checks for msgpack_scalar_encoder_top, with its bind.
// No dependencies.
module mpse_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] out_byte_o,
  input logic       last_o,
  input logic       error_o
);

  a_err_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_o |-> last_o)
    else $error("error result not marked last");

  a_err_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_o |-> out_byte_o == 8'd0)
    else $error("error result carries a nonzero byte");

  a_run_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_o |=> out_valid_o)
    else $error("gap inside a byte run");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(out_byte_o) && $stable(last_o) && $stable(error_o))
    else $error("stalled output word changed");

endmodule

bind msgpack_scalar_encoder_top mpse_checker u_mpse_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_byte_o  (out_byte_o),
  .last_o      (last_o),
  .error_o     (error_o)
);

>>> tb/sv/mpse_encoding_check.sv
// Checker for the MessagePack scalar encoder: watches the input and output channels,
// predicts the byte run of every accepted word and compares each output byte in order.
// Depends on mpse_pkg.
module mpse_encoding_check import mpse_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [1:0]  req_type_i,
  input  logic [63:0] value_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [7:0]  out_byte_i,
  input  logic        last_i,
  input  logic        error_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          words_in_o,
  output int          bytes_out_o,
  output int          errors_out_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxPrinted = 40;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       err;
  } enc_byte_t;

  enc_byte_t expected_bytes_q[$];
  enc_byte_t want;

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] exp_val);
    if (fail_count_o < MaxPrinted) begin
      $display("%0t ns: mismatch on %s: got %0h, expected %0h", $realtime, what, got, exp_val);
    end
    fail_count_o++;
  endtask

  task automatic push_byte(logic [7:0] b);
    expected_bytes_q.push_back('{data: b, last: 1'b0, err: 1'b0});
  endtask

  task automatic push_be(logic [63:0] v, int nbytes);
    for (int i = nbytes - 1; i >= 0; i--) begin
      push_byte(v[8*i +: 8]);
    end
  endtask

  // smallest form for ints, fixed prefix for floats, header for array counts
  task automatic predict_encoding(req_e req, logic [63:0] v);
    case (req)
      REQ_INT: begin
        if (!v[63]) begin
          if (v < 64'h80) begin
            push_byte(v[7:0]);
          end else if (v <= 64'hff) begin
            push_byte(PfxUint8);
            push_be(v, 1);
          end else if (v <= 64'hffff) begin
            push_byte(PfxUint16);
            push_be(v, 2);
          end else if (v <= 64'hffff_ffff) begin
            push_byte(PfxUint32);
            push_be(v, 4);
          end else begin
            push_byte(PfxUint64);
            push_be(v, 8);
          end
        end else begin
          if (v >= 64'hffff_ffff_ffff_ffe0) begin
            push_byte(v[7:0]);
          end else if (v >= 64'hffff_ffff_ffff_ff80) begin
            push_byte(PfxInt8);
            push_be(v, 1);
          end else if (v >= 64'hffff_ffff_ffff_8000) begin
            push_byte(PfxInt16);
            push_be(v, 2);
          end else if (v >= 64'hffff_ffff_8000_0000) begin
            push_byte(PfxInt32);
            push_be(v, 4);
          end else begin
            push_byte(PfxInt64);
            push_be(v, 8);
          end
        end
      end
      REQ_F32: begin
        push_byte(PfxFloat32);
        push_be({32'h0, v[31:0]}, 4);
      end
      REQ_F64: begin
        push_byte(PfxFloat64);
        push_be(v, 8);
      end
      default: begin
        if (v <= 64'hf) begin
          push_byte(PfxFixArray + v[7:0]);
        end else if (v <= 64'hffff) begin
          push_byte(PfxArray16);
          push_be(v, 2);
        end else if (v <= 64'hffff_ffff) begin
          push_byte(PfxArray32);
          push_be(v, 4);
        end else begin
          // count too wide: one flagged word, no encoding
          expected_bytes_q.push_back('{data: 8'h00, last: 1'b0, err: 1'b1});
        end
      end
    endcase
    expected_bytes_q[expected_bytes_q.size() - 1].last = 1'b1;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_bytes_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
      words_in_o   = 0;
      bytes_out_o  = 0;
      errors_out_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        bytes_out_o++;
        if (error_i) begin
          errors_out_o++;
        end
        if (expected_bytes_q.size() == 0) begin
          report_mismatch("unexpected output word", {56'h0, out_byte_i}, 64'h0);
        end else begin
          want = expected_bytes_q.pop_front();
          if (out_byte_i !== want.data) begin
            report_mismatch("out_byte", {56'h0, out_byte_i}, {56'h0, want.data});
          end
          if (last_i !== want.last) begin
            report_mismatch("last", {63'h0, last_i}, {63'h0, want.last});
          end
          if (error_i !== want.err) begin
            report_mismatch("error", {63'h0, error_i}, {63'h0, want.err});
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        words_in_o++;
        predict_encoding(req_e'(req_type_i), value_i);
      end
      pending_o = expected_bytes_q.size();
    end
  end

endmodule

>>> tb/sv/testbench.sv
// Top of the MessagePack scalar encoder testbench: clock, reset, stimulus and verdict.
// Depends on mpse_pkg, msgpack_scalar_encoder_top and mpse_encoding_check.
module testbench import mpse_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit    = 200000;
  localparam int HoldOffCycles = 80;
  localparam int HoldOffWords  = 12;
  localparam int RandomPerMix  = 30;
  localparam int DrainCycles   = 20;

  typedef struct packed {
    req_e        req;
    logic [63:0] v;
  } word_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic [1:0]  req_type_i  = REQ_INT;
  logic [63:0] value_i     = 64'h0;
  logic        out_stall_i = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic [7:0]  out_byte_o;
  logic        last_o;
  logic        error_o;

  int fail_count;
  int pending;
  int words_in;
  int bytes_out;
  int errors_out;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_off_req  = 1'b0;
  int cycle_count   = 0;

  always #1 clk_i = ~clk_i;

  msgpack_scalar_encoder_top i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .req_type_i (req_type_i),
    .value_i    (value_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_byte_o (out_byte_o),
    .last_o     (last_o),
    .error_o    (error_o)
  );

  mpse_encoding_check i_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .req_type_i  (req_type_i),
    .value_i     (value_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_i  (out_byte_o),
    .last_i      (last_o),
    .error_i     (error_o),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .words_in_o  (words_in),
    .bytes_out_o (bytes_out),
    .errors_out_o(errors_out)
  );

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // receiver: random stalls, or one long hold-off on request
  initial begin
    int held;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        out_stall_i <= 1'b1;
        held = 0;
        while (held < HoldOffCycles) begin
          @(negedge clk_i);
          held++;
        end
        hold_off_req = 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  function automatic logic [63:0] random_value();
    logic [63:0] raw;
    raw = {$urandom(), $urandom()};
    case ($urandom_range(3))
      0:       return raw;
      1:       return raw >> $urandom_range(63);
      2:       return ~(raw >> $urandom_range(63));
      default: return raw >> $urandom_range(56, 63);
    endcase
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_word(req_e req, logic [63:0] v);
    int gap;
    if ($urandom_range(99) < send_idle_pct) begin
      gap = $urandom_range(1, 4);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= req;
    value_i    <= v;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  initial begin
    word_t directed_q[$];
    directed_q = '{
      '{REQ_INT,   64'h0},
      '{REQ_INT,   64'h7f},
      '{REQ_INT,   64'h80},
      '{REQ_INT,   64'h100},
      '{REQ_INT,   64'h1_0000},
      '{REQ_INT,   64'hffff_ffff},
      '{REQ_INT,   64'h1_0000_0000},
      '{REQ_INT,   64'h7fff_ffff_ffff_ffff},
      '{REQ_INT,   64'hffff_ffff_ffff_ffff},
      '{REQ_INT,   64'hffff_ffff_ffff_ffe0},
      '{REQ_INT,   64'hffff_ffff_ffff_ffdf},
      '{REQ_INT,   64'hffff_ffff_ffff_ff7f},
      '{REQ_INT,   64'hffff_ffff_ffff_7fff},
      '{REQ_INT,   64'hffff_ffff_7fff_ffff},
      '{REQ_INT,   64'h8000_0000_0000_0000},
      '{REQ_F32,   64'hdead_beef_3f80_0000},
      '{REQ_F64,   64'h4009_21fb_5444_2d18},
      '{REQ_ARRAY, 64'hf},
      '{REQ_ARRAY, 64'h10},
      '{REQ_ARRAY, 64'h1_0000},
      '{REQ_ARRAY, 64'hffff_ffff},
      '{REQ_ARRAY, 64'h1_0000_0000},
      '{REQ_ARRAY, 64'hffff_ffff_ffff_ffff}
    };

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_idle_pct = 27;
    recv_idle_pct = 58;
    foreach (directed_q[k]) begin
      send_word(directed_q[k].req, directed_q[k].v);
    end

    // long receiver hold-off with the sender still pushing, then drain fully
    hold_off_req = 1'b1;
    repeat (HoldOffWords) send_word(REQ_F64, random_value());
    in_valid_i <= 1'b0;
    wait (pending == 0);
    @(negedge clk_i);

    for (int mix = 0; mix < 3; mix++) begin
      case (mix)
        0: begin
          send_idle_pct = 27;
          recv_idle_pct = 58;
        end
        1: begin
          send_idle_pct = 58;
          recv_idle_pct = 27;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      repeat (RandomPerMix) send_word(req_e'($urandom_range(3)), random_value());
    end
    in_valid_i <= 1'b0;

    wait (pending == 0);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Run covered %0d words (directed edges, random mixes, one long hold-off):",
             words_in);
    $display("  %0d output bytes checked, %0d of them flagged as count overflow.",
             bytes_out, errors_out);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
